// ===== rtl/core/bmpe_pkg.sv =====
`default_nettype none
package bmpe_pkg;
  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W = 13;
  localparam int MAX_HALF_SIZE = 2047;
  localparam int SUB_SHIFT = 2;
  localparam int MAX_SPIKES = 20;

  localparam logic [2:0] REG_SHAPE  = 3'd0;
  localparam logic [2:0] REG_SPIKES = 3'd1;
  localparam logic [2:0] REG_RADIUS = 3'd2;
  localparam logic [2:0] REG_ASPECT = 3'd3;
  localparam logic [2:0] REG_COS    = 3'd4;
  localparam logic [2:0] REG_SIN    = 3'd5;

  localparam logic [1:0] SHAPE_CIRCLE  = 2'd0;
  localparam logic [1:0] SHAPE_SQUARE  = 2'd1;
  localparam logic [1:0] SHAPE_DIAMOND = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FOLD, ST_SCALE, ST_SQRT, ST_LOOK, ST_READ, ST_OUT
  } state_t;

  // sector rotation constants, q1.15 with 1.0 = 32768
  function automatic logic signed [17:0] sector_cos(input logic [4:0] n);
    case (n)
      5'd3: return -18'sd16384;  5'd4: return 18'sd0;      5'd5: return 18'sd10126;
      5'd6: return 18'sd16384;   5'd7: return 18'sd20431;  5'd8: return 18'sd23170;
      5'd9: return 18'sd25102;   5'd10: return 18'sd26510; 5'd11: return 18'sd27566;
      5'd12: return 18'sd28378;  5'd13: return 18'sd29015; 5'd14: return 18'sd29523;
      5'd15: return 18'sd29935;  5'd16: return 18'sd30274; 5'd17: return 18'sd30555;
      5'd18: return 18'sd30792;  5'd19: return 18'sd30993; 5'd20: return 18'sd31164;
      default: return 18'sd0;
    endcase
  endfunction

  function automatic logic signed [17:0] sector_sin(input logic [4:0] n);
    case (n)
      5'd3: return 18'sd28378;   5'd4: return 18'sd32768;  5'd5: return 18'sd31164;
      5'd6: return 18'sd28378;   5'd7: return 18'sd25619;  5'd8: return 18'sd23170;
      5'd9: return 18'sd21063;   5'd10: return 18'sd19261; 5'd11: return 18'sd17716;
      5'd12: return 18'sd16384;  5'd13: return 18'sd15228; 5'd14: return 18'sd14218;
      5'd15: return 18'sd13328;  5'd16: return 18'sd12540; 5'd17: return 18'sd11837;
      5'd18: return 18'sd11207;  5'd19: return 18'sd10640; 5'd20: return 18'sd10126;
      default: return 18'sd0;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/brush_mask_pixel_eval_top.sv =====
`default_nettype none
// Brush mask pixel evaluator. A transaction with op 0 writes one falloff
// table entry, and table writes can run back to back. A transaction with
// op 1 evaluates one pixel offset and returns one alpha. It passes through
// the fold rotations, of which there are at most spike_count/2, capped at
// 10, then the aspect scale, the shape distance and the table read.
// The circle shape adds a square root: one step to load it and 23 steps
// of two bits each. The other shapes skip the square root. After a table
// write, or after the edge that delivers the alpha, the next transaction
// can be accepted in the cycle that follows. One item is in flight at a
// time and in stall stays high until its alpha is taken. The result holds
// while out stall is high.
module brush_mask_pixel_eval_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [17:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [12:0] table_index,
  input  wire logic [7:0]  table_value,
  input  wire logic signed [11:0] pixel_x,
  input  wire logic signed [11:0] pixel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       alpha
);
  logic [1:0]  shape_select;
  logic [4:0]  spike_count;
  logic [11:0] radius_quarters;
  logic [17:0] aspect_q8;
  logic signed [15:0] rot_cos, rot_sin;

  bmpe_pkg::state_t state, state_next;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_select <= 2'd0; spike_count <= 5'd2; radius_quarters <= 12'd20;
      aspect_q8 <= 18'd256; rot_cos <= 16'sd32767; rot_sin <= 16'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmpe_pkg::REG_SHAPE:  shape_select <= cfg_data[1:0];
        bmpe_pkg::REG_SPIKES: spike_count <= cfg_data[4:0];
        bmpe_pkg::REG_RADIUS: radius_quarters <= cfg_data[11:0];
        bmpe_pkg::REG_ASPECT: aspect_q8 <= cfg_data;
        bmpe_pkg::REG_COS:    rot_cos <= cfg_data[15:0];
        bmpe_pkg::REG_SIN:    rot_sin <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_stall = (state != bmpe_pkg::ST_IDLE);
  assign in_acc = in_valid && !in_stall;

  // datapath registers
  logic signed [29:0] rx, ry;
  logic [4:0]  fold_left;
  logic signed [17:0] sc, ss;
  logic        outside;
  logic [22:0] atx, aty;
  logic [23:0] root;
  logic [4:0]  sq_step;
  logic [23:0] distance;
  logic        zero_res;
  logic [7:0]  rdata;

  // rotation by brush angle at accept
  logic signed [29:0] rot_x, rot_y;
  assign rot_x = 30'(rot_cos * pixel_x) - 30'(rot_sin * pixel_y);
  assign rot_y = 30'(rot_sin * pixel_x) + 30'(rot_cos * pixel_y);

  // one fold rotation step
  logic signed [48:0] pcx, psy, pcy, psx, fx, fy;
  logic fold_go;
  assign pcx = 49'(sc * rx);
  assign psy = 49'(ss * ry);
  assign pcy = 49'(sc * ry);
  assign psx = 49'(ss * rx);
  assign fold_go = (fold_left != 5'd0) && ((pcx + psy) > (49'(rx) <<< 15));
  assign fx = (pcx + psy + 49'sd16384) >>> 15;
  assign fy = (pcy - psx + 49'sd16384) >>> 15;

  // aspect scale
  logic signed [48:0] tyw, tyw_abs;
  logic signed [22:0] txw;
  assign tyw = (49'(ry) * $signed({1'b0, aspect_q8}) + 49'sd16384) >>> 15;
  assign tyw_abs = tyw[48] ? -tyw : tyw;
  assign txw = 23'((rx + 30'sd64) >>> 7);

  // square root step, two bits a cycle
  logic [45:0] radicand;
  logic [47:0] root_rem;
  logic [47:0] partial;
  logic [47:0] r_try;
  assign partial = {root_rem[45:0], radicand[45:44]};
  assign r_try = {22'd0, root, 2'b01};

  logic [48:0] d_limit;
  logic [26:0] idx_w;
  assign d_limit = 49'((radius_quarters + 13'd4)) << 6;
  assign idx_w = (27'(distance) << bmpe_pkg::SUB_SHIFT) + 27'd128 >> 8;

  logic [45:0] sq_sum;
  assign sq_sum = 46'(atx * atx) + 46'(aty * aty);

  always_comb begin
    state_next = state;
    unique case (state)
      bmpe_pkg::ST_IDLE:  if (in_acc && op) state_next = bmpe_pkg::ST_FOLD;
      bmpe_pkg::ST_FOLD:  if (!fold_go) state_next = bmpe_pkg::ST_SCALE;
      bmpe_pkg::ST_SCALE: state_next = (shape_select == bmpe_pkg::SHAPE_CIRCLE)
                                       ? bmpe_pkg::ST_SQRT : bmpe_pkg::ST_LOOK;
      bmpe_pkg::ST_SQRT:  if (sq_step == 5'd0) state_next = bmpe_pkg::ST_LOOK;
      bmpe_pkg::ST_LOOK:  state_next = bmpe_pkg::ST_READ;
      bmpe_pkg::ST_READ:  state_next = bmpe_pkg::ST_OUT;
      bmpe_pkg::ST_OUT:   if (!out_stall) state_next = bmpe_pkg::ST_IDLE;
      default: state_next = bmpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bmpe_pkg::ST_IDLE;
    else state <= state_next;
  end

  assign out_valid = (state == bmpe_pkg::ST_OUT);
  assign alpha = zero_res ? 8'd0 : rdata;

  always_ff @(posedge clk) begin
    unique case (state)
      bmpe_pkg::ST_IDLE: begin
        rx <= rot_x;
        ry <= rot_y[29] ? -rot_y : rot_y;
        outside <= (pixel_x == -12'sd2048) || (pixel_y == -12'sd2048);
        sc <= bmpe_pkg::sector_cos(spike_count > 5'd20 ? 5'd20 : spike_count);
        ss <= bmpe_pkg::sector_sin(spike_count > 5'd20 ? 5'd20 : spike_count);
        fold_left <= (spike_count > 5'd2)
                   ? ((spike_count > 5'd20 ? 5'd20 : spike_count) >> 1) : 5'd0;
      end
      bmpe_pkg::ST_FOLD: begin
        if (fold_go) begin
          rx <= 30'(fx);
          ry <= 30'(fy);
          fold_left <= fold_left - 5'd1;
        end
      end
      bmpe_pkg::ST_SCALE: begin
        atx <= txw[22] ? 23'(-txw) : txw;
        // clamp far points, they land past the radius limit either way
        aty <= (tyw_abs > 49'sd4194303) ? 23'd4194303 : 23'(tyw_abs);
      end
      default: ;
    endcase
    // distance
    if (state == bmpe_pkg::ST_SCALE) begin
      sq_step <= 5'd23;
      root <= 24'd0;
      root_rem <= 48'd0;
    end
    if (state == bmpe_pkg::ST_SQRT) begin
      if (sq_step == 5'd23) begin
        radicand <= sq_sum;
        sq_step <= 5'd22;
      end else begin
        radicand <= {radicand[43:0], 2'b00};
        sq_step <= sq_step - 5'd1;
        if (partial >= r_try) begin
          root_rem <= partial - r_try;
          root <= {root[22:0], 1'b1};
        end else begin
          root_rem <= partial;
          root <= {root[22:0], 1'b0};
        end
      end
    end
    if (state == bmpe_pkg::ST_LOOK) begin
      unique case (shape_select)
        bmpe_pkg::SHAPE_CIRCLE:  distance <= root;
        bmpe_pkg::SHAPE_SQUARE:  distance <= 24'(atx > aty ? atx : aty);
        bmpe_pkg::SHAPE_DIAMOND: distance <= 24'(atx) + 24'(aty);
        default: distance <= 24'd0;
      endcase
    end
    if (state == bmpe_pkg::ST_READ) begin
      zero_res <= outside || (49'(distance) >= d_limit)
                  || (idx_w >= 27'(bmpe_pkg::TABLE_DEPTH));
    end
  end

  // table address: register distance in LOOK, present index in READ
  logic [12:0] ram_raddr;
  assign ram_raddr = idx_w[12:0];
  logic ram_we;
  assign ram_we = in_acc && !op;

  bmpe_ram #(.WIDTH(8), .DEPTH(bmpe_pkg::TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (table_index),
    .wdata (table_value),
    .raddr (ram_raddr),
    .rdata (rdata)
  );
endmodule
`default_nettype wire

// ===== rtl/core/bmpe_ram.sv =====
`default_nettype none
module bmpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== dv/brush_mask_pixel_eval_top_tb.sv =====
`timescale 1ns / 1ps
module brush_mask_pixel_eval_top_tb;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 80;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [17:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               op;
  logic [12:0]        table_index;
  logic [7:0]         table_value;
  logic signed [11:0] pixel_x;
  logic signed [11:0] pixel_y;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         alpha;

  brush_mask_pixel_eval_top uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .table_index(table_index), .table_value(table_value),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .out_valid(out_valid), .out_stall(out_stall), .alpha(alpha)
  );

  // fold rotation constants per spike count, q1.15
  int fold_cos[21] = '{0, 0, 0, -16384, 0, 10126, 16384, 20431, 23170, 25102, 26510,
                       27566, 28378, 29015, 29523, 29935, 30274, 30555, 30792, 30993, 31164};
  int fold_sin[21] = '{0, 0, 0, 28378, 32768, 31164, 28378, 25619, 23170, 21063, 19261,
                       17716, 16384, 15228, 14218, 13328, 12540, 11837, 11207, 10640, 10126};

  // predicted block state
  logic [7:0]  falloff_mem [bmpe_pkg::TABLE_DEPTH];
  bit          loaded [bmpe_pkg::TABLE_DEPTH];
  logic [1:0]  shape_m;
  logic [4:0]  spikes_m;
  logic [11:0] radius_m;
  logic [17:0] aspect_m;
  longint      cos_m;
  longint      sin_m;

  logic [7:0] alpha_q[$];
  int         errors;
  int         idle_cycles;
  int         hold_cycles;
  bit         no_gaps;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // rd_idx gives the table entry read, or -1 when none is read
  function automatic logic [7:0] pixel_alpha(logic signed [11:0] px, logic signed [11:0] py,
                                             output int rd_idx);
    longint x, y, rx, ry, c, s, nx, ny, tx, ty, atx, aty;
    longint unsigned d, idx;
    int n;
    rd_idx = -1;
    x = px;
    y = py;
    n = (spikes_m > 20) ? 20 : spikes_m;
    if (x > bmpe_pkg::MAX_HALF_SIZE || x < -bmpe_pkg::MAX_HALF_SIZE ||
        y > bmpe_pkg::MAX_HALF_SIZE || y < -bmpe_pkg::MAX_HALF_SIZE)
      return 8'd0;
    rx = cos_m * x - sin_m * y;
    ry = sin_m * x + cos_m * y;
    if (ry < 0) ry = -ry;
    // turn back by one sector while closer to the next spike
    if (n > 2) begin
      c = fold_cos[n];
      s = fold_sin[n];
      for (int k = 0; k < n / 2; k++) begin
        if (!(rx * c + ry * s > rx * 32768)) break;
        nx = (c * rx + s * ry + 16384) >>> 15;
        ny = (c * ry - s * rx + 16384) >>> 15;
        rx = nx;
        ry = ny;
      end
    end
    tx = (rx + 64) >>> 7;
    ty = (ry * longint'(aspect_m) + 16384) >>> 15;
    atx = (tx < 0) ? -tx : tx;
    aty = (ty < 0) ? -ty : ty;
    case (shape_m)
      bmpe_pkg::SHAPE_CIRCLE:  d = int_sqrt(atx * atx + aty * aty);
      bmpe_pkg::SHAPE_SQUARE:  d = (atx > aty) ? atx : aty;
      bmpe_pkg::SHAPE_DIAMOND: d = atx + aty;
      default:                 d = 0;
    endcase
    if (d >= (longint'(radius_m) + 4) * 64) return 8'd0;
    idx = (d * 4 + 128) >> 8;
    if (idx >= bmpe_pkg::TABLE_DEPTH) return 8'd0;
    rd_idx = int'(idx);
    return falloff_mem[idx];
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // one input transaction, predicted on acceptance
  task automatic send_item(logic o, logic [12:0] ti, logic [7:0] tv,
                           logic signed [11:0] x, logic signed [11:0] y);
    int g;
    int ri;
    logic [7:0] want;
    // a pixel that would read an unloaded entry gets that entry written first
    if (o == 1'b1) begin
      void'(pixel_alpha(x, y, ri));
      if (ri >= 0 && !loaded[ri])
        send_item(1'b0, 13'(ri), 8'($urandom_range(255)), 12'sd0, 12'sd0);
    end
    in_valid <= 1'b1;
    op <= o;
    table_index <= ti;
    table_value <= tv;
    pixel_x <= x;
    pixel_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (o == 1'b0) begin
      falloff_mem[ti] = tv;
      loaded[ti] = 1'b1;
    end else begin
      want = pixel_alpha(x, y, ri);
      alpha_q.push_back(want);
    end
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (alpha_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [17:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bmpe_pkg::REG_SHAPE:  shape_m = val[1:0];
      bmpe_pkg::REG_SPIKES: spikes_m = val[4:0];
      bmpe_pkg::REG_RADIUS: radius_m = val[11:0];
      bmpe_pkg::REG_ASPECT: aspect_m = val;
      bmpe_pkg::REG_COS:    cos_m = longint'($signed(val[15:0]));
      bmpe_pkg::REG_SIN:    sin_m = longint'($signed(val[15:0]));
      default: ;
    endcase
  endtask

  task automatic set_all(logic [1:0] sh, logic [4:0] sp, logic [11:0] rad,
                         logic [17:0] asp, logic [15:0] c, logic [15:0] s);
    drain();
    set_reg(bmpe_pkg::REG_SHAPE, 18'(sh));
    set_reg(bmpe_pkg::REG_SPIKES, 18'(sp));
    set_reg(bmpe_pkg::REG_RADIUS, 18'(rad));
    set_reg(bmpe_pkg::REG_ASPECT, asp);
    set_reg(bmpe_pkg::REG_COS, 18'(c));
    set_reg(bmpe_pkg::REG_SIN, 18'(s));
  endtask

  function automatic logic signed [11:0] rand_coord();
    int span;
    span = int'(radius_m) / 4 + 3;
    if (span > 2047) span = 2047;
    if ($urandom_range(1) == 0) return 12'($urandom_range(4095));
    return 12'(int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic rand_pixel();
    if ($urandom_range(4) == 0)
      send_item(1'b0, 13'($urandom_range(8191)), 8'($urandom_range(255)), 12'sd0, 12'sd0);
    else
      send_item(1'b1, 13'($urandom_range(8191)), 8'($urandom_range(255)),
                rand_coord(), rand_coord());
  endtask

  // back-to-back writes over the low entries and the top one;
  // pixels get any other entry they need written before they are sent
  task automatic test_table_load();
    no_gaps = 1'b1;
    for (int i = 0; i < 64; i++)
      send_item(1'b0, 13'(i), 8'($urandom_range(255)), 12'sd0, 12'sd0);
    send_item(1'b0, 13'd8191, 8'hff, 12'sd0, 12'sd0);
    send_item(1'b0, 13'd0, 8'h00, 12'sd0, 12'sd0);
    send_item(1'b0, 13'd5, 8'ha5, 12'sd0, 12'sd0);
    no_gaps = 1'b0;
  endtask

  // corner offsets under reset settings, then odd shapes and spike counts
  task automatic test_directed();
    send_item(1'b1, 13'd0, 8'd0, 12'sd0, 12'sd0);
    send_item(1'b1, 13'd0, 8'd0, 12'sd5, -12'sd3);
    send_item(1'b1, 13'd0, 8'd0, 12'sd2047, 12'sd2047);
    send_item(1'b1, 13'd0, 8'd0, -12'sd2047, -12'sd2047);
    send_item(1'b1, 13'd0, 8'd0, -12'sd2048, 12'sd0);
    send_item(1'b1, 13'd0, 8'd0, 12'sd0, -12'sd2048);
    send_item(1'b1, 13'd0, 8'd0, 12'sd6, 12'sd0);
    set_all(2'd3, 5'd3, 12'd0, 18'd0, 16'h8000, 16'h7fff);
    send_item(1'b1, 13'd0, 8'd0, 12'sd1, -12'sd1);
    send_item(1'b1, 13'd0, 8'd0, -12'sd2048, 12'sd1);
    set_all(bmpe_pkg::SHAPE_SQUARE, 5'd31, 12'd4095, 18'h3ffff, 16'h5a82, 16'h5a82);
    send_item(1'b1, 13'd0, 8'd0, 12'sd2047, -12'sd2047);
    send_item(1'b1, 13'd0, 8'd0, 12'sd300, 12'sd9);
    set_all(bmpe_pkg::SHAPE_DIAMOND, 5'd0, 12'd4092, 18'd256000, 16'h7fff, 16'h8000);
    send_item(1'b1, 13'd0, 8'd0, -12'sd1000, 12'sd2);
    send_item(1'b1, 13'd0, 8'd0, 12'sd1000, -12'sd2047);
    set_all(bmpe_pkg::SHAPE_CIRCLE, 5'd4, 12'd400, 18'd512, 16'h0000, 16'h7fff);
    send_item(1'b1, 13'd0, 8'd0, 12'sd70, 12'sd40);
    send_item(1'b1, 13'd0, 8'd0, -12'sd70, 12'sd40);
    set_all(bmpe_pkg::SHAPE_CIRCLE, 5'd20, 12'd800, 18'd256, 16'h7fff, 16'h0000);
    send_item(1'b1, 13'd0, 8'd0, 12'sd150, 12'sd150);
    send_item(1'b1, 13'd0, 8'd0, -12'sd150, 12'sd20);
  endtask

  // random items across random and extreme settings
  task automatic test_random();
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_all(bmpe_pkg::SHAPE_CIRCLE, 5'd2, 12'd20, 18'd256, 16'h7fff, 16'h0000);
        1: set_all(bmpe_pkg::SHAPE_SQUARE, 5'd20, 12'd4092, 18'd256000, 16'h8000, 16'h0000);
        2: set_all(bmpe_pkg::SHAPE_DIAMOND, 5'd3, 12'd0, 18'd256, 16'h0000, 16'h8000);
        default:
          set_all(2'($urandom_range(3)), 5'($urandom_range(31)), 12'($urandom_range(4095)),
                  ($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(1024, 128)),
                  16'($urandom), 16'($urandom));
      endcase
      if (ph == 4) no_gaps = 1'b1;
      repeat (90) rand_pixel();
      no_gaps = 1'b0;
    end
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    set_all(bmpe_pkg::SHAPE_CIRCLE, 5'd6, 12'd200, 18'd300, 16'h6000, 16'h2000);
    hold_cycles = 400;
    no_gaps = 1'b1;
    repeat (30) rand_pixel();
    no_gaps = 1'b0;
  endtask

  // receiver stall pattern
  initial begin
    int r;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 55) begin
          out_stall <= 1'b0;
        end else if (r < 95) begin
          out_stall <= 1'b1;
        end else begin
          hold_cycles = $urandom_range(40, 10);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (alpha_q.size() == 0) begin
        report("unexpected alpha", alpha, -1);
      end else begin
        want = alpha_q.pop_front();
        if (alpha !== want) report("alpha", alpha, want);
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    op = 1'b0;
    table_index = '0;
    table_value = '0;
    pixel_x = '0;
    pixel_y = '0;
    errors = 0;
    idle_cycles = 0;
    hold_cycles = 0;
    no_gaps = 1'b0;
    shape_m = bmpe_pkg::SHAPE_CIRCLE;
    spikes_m = 5'd2;
    radius_m = 12'd20;
    aspect_m = 18'd256;
    cos_m = 32767;
    sin_m = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
